// ===== hdl/i2cebam_pkg.sv =====
`timescale 1ns / 1ps
// Package for the I2C EEPROM byte access master: sizes, request and
// register codes, sequencer phase type and the byte selection function.
package i2cebam_pkg;

  localparam int ADDR_WIDTH        = 16;
  localparam int WRITE_WAIT_PHASES = 5;
  localparam int WAIT_W            = 7;
  localparam int TIMER_W           = 16;
  localparam int DEV_W             = 7;
  localparam int CFG_IDX_W         = 2;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS    = 2'd1;

  localparam logic [DEV_W-1:0]   DEV_ADDR_RESET    = 7'd80;
  localparam logic [TIMER_W-1:0] PHASE_TICKS_RESET = 16'd1;

  localparam logic [2:0] BYTE_CTRL    = 3'd0;
  localparam logic [2:0] BYTE_ADDR_HI = 3'd1;
  localparam logic [2:0] BYTE_ADDR_LO = 3'd2;
  localparam logic [2:0] BYTE_LAST    = 3'd3;

  typedef enum logic [14:0] {
    PH_IDLE   = 15'b000000000000001,
    PH_ST_A   = 15'b000000000000010,
    PH_ST_B   = 15'b000000000000100,
    PH_BIT_LO = 15'b000000000001000,
    PH_BIT_HI = 15'b000000000010000,
    PH_ACK_LO = 15'b000000000100000,
    PH_ACK_HI = 15'b000000001000000,
    PH_RD_LO  = 15'b000000010000000,
    PH_RD_HI  = 15'b000000100000000,
    PH_NB_LO  = 15'b000001000000000,
    PH_NB_HI  = 15'b000010000000000,
    PH_SP_A   = 15'b000100000000000,
    PH_SP_B   = 15'b001000000000000,
    PH_SP_C   = 15'b010000000000000,
    PH_WAIT   = 15'b100000000000000
  } phase_t;

  function automatic logic [7:0] byte_for(input logic [2:0]       idx,
                                          input logic [DEV_W-1:0] dev,
                                          input logic [15:0]      addr,
                                          input logic [7:0]       data,
                                          input logic             rd);
    logic [7:0] ctrl;
    ctrl = {dev, 1'b0};
    unique case (idx)
      BYTE_CTRL:    byte_for = ctrl;
      BYTE_ADDR_HI: byte_for = addr[15:8];
      BYTE_ADDR_LO: byte_for = addr[7:0];
      default:      byte_for = rd ? {dev, 1'b1} : data;
    endcase
  endfunction

endpackage

// ===== hdl/i2c_eeprom_byte_access_master.sv =====
`timescale 1ns / 1ps
// I2C EEPROM byte access master: one byte write or random byte read per write/read request.
// The result sits in the output register from the edge after acceptance.
// Throughput: one request per cycle; the sequencer and phase timer advance in a single pass.
// A stalled result holds the input off; a new request enters as the waiting result leaves.
// Reset: synchronous; idles the sequencer, clears out_valid, restores register defaults.
// Depends on i2cebam_pkg.
module i2c_eeprom_byte_access_master
  import i2cebam_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           func,
  input  logic [15:0]          mem_addr,
  input  logic [7:0]           write_data,
  input  logic                 sda_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 scl_out,
  output logic                 sda_out,
  output logic                 busy_res,
  output logic                 done_res,
  output logic                 nack,
  output logic [7:0]           read_data
);

  logic [DEV_W-1:0]      device_address;
  logic [TIMER_W-1:0]    phase_ticks;

  phase_t                state, state_next;
  logic [2:0]            byte_index, byte_index_next;
  logic [3:0]            bit_count, bit_count_next;
  logic [7:0]            shift_out, shift_out_next;
  logic [7:0]            shift_in, shift_in_next;
  logic [TIMER_W-1:0]    phase_timer, phase_timer_next;
  logic [ADDR_WIDTH-1:0] latched_address, latched_address_next;
  logic [7:0]            latched_data, latched_data_next;
  logic                  is_read, is_read_next;
  logic                  nack_seen, nack_seen_next;
  logic [WAIT_W-1:0]     wait_count, wait_count_next;

  logic                  accept;
  logic                  done_next;
  logic                  scl_next, sda_next, busy_next;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= DEV_ADDR_RESET;
      phase_ticks    <= PHASE_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEVICE_ADDRESS: device_address <= cfg_data[DEV_W-1:0];
        CFG_PHASE_TICKS:    phase_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [TIMER_W-1:0] limit;
    logic [TIMER_W-1:0] timer_inc;
    logic [2:0]         nxt;
    logic [15:0]        addr16;

    state_next           = state;
    byte_index_next      = byte_index;
    bit_count_next       = bit_count;
    shift_out_next       = shift_out;
    shift_in_next        = shift_in;
    phase_timer_next     = phase_timer;
    latched_address_next = latched_address;
    latched_data_next    = latched_data;
    is_read_next         = is_read;
    nack_seen_next       = nack_seen;
    wait_count_next      = wait_count;
    done_next            = 1'b0;
    limit                = (phase_ticks == '0) ? TIMER_W'(1) : phase_ticks;
    timer_inc            = phase_timer + TIMER_W'(1);
    nxt                  = byte_index + 3'd1;
    addr16               = 16'(latched_address);

    if ((func == FUNC_WRITE || func == FUNC_READ) && state == PH_IDLE) begin
      latched_address_next = mem_addr[ADDR_WIDTH-1:0];
      latched_data_next    = write_data;
      is_read_next         = (func == FUNC_READ);
      nack_seen_next       = 1'b0;
      shift_in_next        = '0;
      shift_out_next       = '0;
      byte_index_next      = '0;
      bit_count_next       = '0;
      wait_count_next      = '0;
      phase_timer_next     = '0;
      state_next           = PH_ST_A;
    end else if (func == FUNC_TICK && state != PH_IDLE) begin
      if (timer_inc >= limit) begin
        phase_timer_next = '0;
        unique case (state)
          PH_ST_A: state_next = PH_ST_B;
          PH_ST_B: begin
            shift_out_next = byte_for(byte_index, device_address, addr16,
                                      latched_data, is_read);
            bit_count_next = '0;
            state_next     = PH_BIT_LO;
          end
          PH_BIT_LO: state_next = PH_BIT_HI;
          PH_BIT_HI: begin
            shift_out_next = {shift_out[6:0], 1'b0};
            bit_count_next = bit_count + 4'd1;
            state_next     = (bit_count_next >= 4'd8) ? PH_ACK_LO : PH_BIT_LO;
          end
          PH_ACK_LO: state_next = PH_ACK_HI;
          PH_ACK_HI: begin
            if (sda_in) begin
              nack_seen_next = 1'b1;
              state_next     = PH_SP_A;
            end else if (byte_index >= BYTE_LAST) begin
              if (is_read) begin
                shift_in_next  = '0;
                bit_count_next = '0;
                state_next     = PH_RD_LO;
              end else begin
                state_next = PH_SP_A;
              end
            end else if (byte_index == BYTE_ADDR_LO && is_read) begin
              byte_index_next = BYTE_LAST;
              state_next      = PH_ST_A;
            end else begin
              if (nxt == BYTE_ADDR_HI && ADDR_WIDTH <= 8) begin
                nxt = BYTE_ADDR_LO;
              end
              byte_index_next = nxt;
              shift_out_next  = byte_for(nxt, device_address, addr16,
                                         latched_data, is_read);
              bit_count_next  = '0;
              state_next      = PH_BIT_LO;
            end
          end
          PH_RD_LO: state_next = PH_RD_HI;
          PH_RD_HI: begin
            shift_in_next  = {shift_in[6:0], sda_in};
            bit_count_next = bit_count + 4'd1;
            state_next     = (bit_count_next >= 4'd8) ? PH_NB_LO : PH_RD_LO;
          end
          PH_NB_LO: state_next = PH_NB_HI;
          PH_NB_HI: state_next = PH_SP_A;
          PH_SP_A:  state_next = PH_SP_B;
          PH_SP_B:  state_next = PH_SP_C;
          PH_SP_C: begin
            if (!is_read && !nack_seen && WRITE_WAIT_PHASES > 0) begin
              wait_count_next = '0;
              state_next      = PH_WAIT;
            end else begin
              state_next = PH_IDLE;
              done_next  = 1'b1;
            end
          end
          PH_WAIT: begin
            wait_count_next = wait_count + WAIT_W'(1);
            if (wait_count_next >= WAIT_W'(WRITE_WAIT_PHASES)) begin
              state_next = PH_IDLE;
              done_next  = 1'b1;
            end
          end
          default: state_next = PH_IDLE;
        endcase
      end else begin
        phase_timer_next = timer_inc;
      end
    end

    scl_next = 1'b1;
    sda_next = 1'b1;
    unique case (state_next)
      PH_ST_B:   sda_next = 1'b0;
      PH_BIT_LO: begin
        scl_next = 1'b0;
        sda_next = shift_out_next[7];
      end
      PH_BIT_HI: sda_next = shift_out_next[7];
      PH_ACK_LO, PH_RD_LO, PH_NB_LO: scl_next = 1'b0;
      PH_SP_A: begin
        scl_next = 1'b0;
        sda_next = 1'b0;
      end
      PH_SP_B: sda_next = 1'b0;
      default: ;
    endcase
    busy_next = (state_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= PH_IDLE;
      byte_index      <= '0;
      bit_count       <= '0;
      shift_out       <= '0;
      shift_in        <= '0;
      phase_timer     <= '0;
      latched_address <= '0;
      latched_data    <= '0;
      is_read         <= 1'b0;
      nack_seen       <= 1'b0;
      wait_count      <= '0;
    end else if (accept) begin
      state           <= state_next;
      byte_index      <= byte_index_next;
      bit_count       <= bit_count_next;
      shift_out       <= shift_out_next;
      shift_in        <= shift_in_next;
      phase_timer     <= phase_timer_next;
      latched_address <= latched_address_next;
      latched_data    <= latched_data_next;
      is_read         <= is_read_next;
      nack_seen       <= nack_seen_next;
      wait_count      <= wait_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scl_out   <= scl_next;
      sda_out   <= sda_next;
      busy_res  <= busy_next;
      done_res  <= done_next;
      nack      <= !busy_next && nack_seen_next;
      read_data <= (!busy_next && is_read_next && !nack_seen_next) ? shift_in_next : 8'd0;
    end
  end

`ifndef ASSERT_OFF
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done reported while still busy");

  a_idle_lines_high: assert property (@(posedge clk) disable iff (rst)
    out_valid && !busy_res |-> scl_out && sda_out)
    else $error("bus lines not released while idle");

  a_nack_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && nack |-> read_data == 8'd0)
    else $error("read data shown after a missing acknowledge");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input held off with no pending result");
`endif

endmodule

// ===== tb/tb_i2c_eeprom_byte_access_master.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the I2C EEPROM byte access master: a bus-level
// predictor follows every request and the pin results are compared one by one.
// Depends on i2cebam_pkg and i2c_eeprom_byte_access_master.
module tb_i2c_eeprom_byte_access_master;
  import i2cebam_pkg::*;

  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam int WORK_TARGET = 1300;
  localparam int IDLE_LIMIT  = 2000;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic       nack;
    logic [7:0] rdata;
  } line_status_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           func = FUNC_TICK;
  logic [15:0]          mem_addr = '0;
  logic [7:0]           write_data = '0;
  logic                 sda_in = 1'b1;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 scl_out;
  logic                 sda_out;
  logic                 busy_res;
  logic                 done_res;
  logic                 nack;
  logic [7:0]           read_data;

  line_status_t bus_expect_q[$];
  int  fails = 0;
  int  work_items = 0;
  int  quiet_cycles = 0;
  bit  steady = 1'b0;

  // predictor state
  logic [DEV_W-1:0]   model_dev;
  logic [TIMER_W-1:0] model_ticks;
  phase_t             m_phase;
  logic [2:0]         m_byte;
  logic [3:0]         m_bits;
  logic [7:0]         m_shift_out;
  logic [7:0]         m_shift_in;
  logic [15:0]        m_timer;
  logic [15:0]        m_addr;
  logic [7:0]         m_data;
  logic               m_rd;
  logic               m_nacked;
  logic [WAIT_W-1:0]  m_wait;

  i2c_eeprom_byte_access_master uut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic void reset_bus_model();
    model_dev   = DEV_ADDR_RESET;
    model_ticks = PHASE_TICKS_RESET;
    m_phase     = PH_IDLE;
    m_byte      = '0;
    m_bits      = '0;
    m_shift_out = '0;
    m_shift_in  = '0;
    m_timer     = '0;
    m_addr      = '0;
    m_data      = '0;
    m_rd        = 1'b0;
    m_nacked    = 1'b0;
    m_wait      = '0;
  endfunction

  function automatic logic [7:0] byte_to_send(input logic [2:0] idx);
    case (idx)
      BYTE_CTRL:    byte_to_send = {model_dev, 1'b0};
      BYTE_ADDR_HI: byte_to_send = m_addr[15:8];
      BYTE_ADDR_LO: byte_to_send = m_addr[7:0];
      default:      byte_to_send = m_rd ? {model_dev, 1'b1} : m_data;
    endcase
  endfunction

  function automatic void load_next_byte(input logic [2:0] idx);
    m_byte      = idx;
    m_shift_out = byte_to_send(idx);
    m_bits      = '0;
    m_phase     = PH_BIT_LO;
  endfunction

  function automatic logic close_phase(input logic sda);
    logic [2:0] nxt;
    close_phase = 1'b0;
    case (m_phase)
      PH_ST_A:   m_phase = PH_ST_B;
      PH_ST_B:   load_next_byte(m_byte);
      PH_BIT_LO: m_phase = PH_BIT_HI;
      PH_BIT_HI: begin
        m_shift_out = m_shift_out << 1;
        m_bits      = m_bits + 4'd1;
        m_phase     = (m_bits >= 4'd8) ? PH_ACK_LO : PH_BIT_LO;
      end
      PH_ACK_LO: m_phase = PH_ACK_HI;
      PH_ACK_HI: begin
        if (sda) begin
          m_nacked = 1'b1;
          m_phase  = PH_SP_A;
        end else if (m_byte >= BYTE_LAST) begin
          if (m_rd) begin
            m_shift_in = '0;
            m_bits     = '0;
            m_phase    = PH_RD_LO;
          end else begin
            m_phase = PH_SP_A;
          end
        end else if (m_byte == BYTE_ADDR_LO && m_rd) begin
          m_byte  = BYTE_LAST;
          m_phase = PH_ST_A;
        end else begin
          nxt = m_byte + 3'd1;
          if (nxt == BYTE_ADDR_HI && ADDR_WIDTH <= 8) nxt = BYTE_ADDR_LO;
          load_next_byte(nxt);
        end
      end
      PH_RD_LO:  m_phase = PH_RD_HI;
      PH_RD_HI: begin
        m_shift_in = {m_shift_in[6:0], sda};
        m_bits     = m_bits + 4'd1;
        m_phase    = (m_bits >= 4'd8) ? PH_NB_LO : PH_RD_LO;
      end
      PH_NB_LO:  m_phase = PH_NB_HI;
      PH_NB_HI:  m_phase = PH_SP_A;
      PH_SP_A:   m_phase = PH_SP_B;
      PH_SP_B:   m_phase = PH_SP_C;
      PH_SP_C: begin
        if (!m_rd && !m_nacked && WRITE_WAIT_PHASES > 0) begin
          m_wait  = '0;
          m_phase = PH_WAIT;
        end else begin
          m_phase     = PH_IDLE;
          close_phase = 1'b1;
        end
      end
      PH_WAIT: begin
        m_wait = m_wait + 1'b1;
        if (m_wait >= WRITE_WAIT_PHASES) begin
          m_phase     = PH_IDLE;
          close_phase = 1'b1;
        end
      end
      default:   m_phase = PH_IDLE;
    endcase
  endfunction

  function automatic line_status_t advance_bus_model(input logic [1:0]  f,
                                                     input logic [15:0] a,
                                                     input logic [7:0]  d,
                                                     input logic        s);
    line_status_t r;
    logic         fin;
    logic [15:0]  lim;
    fin = 1'b0;
    if ((f == FUNC_WRITE || f == FUNC_READ) && m_phase == PH_IDLE) begin
      m_addr      = a & 16'((32'd1 << ADDR_WIDTH) - 1);
      m_data      = d;
      m_rd        = (f == FUNC_READ);
      m_nacked    = 1'b0;
      m_shift_in  = '0;
      m_shift_out = '0;
      m_byte      = BYTE_CTRL;
      m_bits      = '0;
      m_wait      = '0;
      m_timer     = '0;
      m_phase     = PH_ST_A;
    end else if (f == FUNC_TICK && m_phase != PH_IDLE) begin
      lim     = (model_ticks == '0) ? 16'd1 : model_ticks;
      m_timer = m_timer + 16'd1;
      if (m_timer >= lim) begin
        m_timer = '0;
        fin     = close_phase(s);
      end
    end
    r.scl = 1'b1;
    r.sda = 1'b1;
    case (m_phase)
      PH_ST_B: r.sda = 1'b0;
      PH_BIT_LO: begin
        r.scl = 1'b0;
        r.sda = m_shift_out[7];
      end
      PH_BIT_HI: r.sda = m_shift_out[7];
      PH_ACK_LO, PH_RD_LO, PH_NB_LO: r.scl = 1'b0;
      PH_SP_A: begin
        r.scl = 1'b0;
        r.sda = 1'b0;
      end
      PH_SP_B: r.sda = 1'b0;
      default: ;
    endcase
    r.busy  = (m_phase != PH_IDLE);
    r.done  = fin;
    r.nack  = r.busy ? 1'b0 : m_nacked;
    r.rdata = (!r.busy && m_rd && !m_nacked) ? m_shift_in : 8'd0;
    return r;
  endfunction

  task automatic send_item(input logic [1:0] f, input logic [15:0] a,
                           input logic [7:0] d, input logic s);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    func       <= f;
    mem_addr   <= a;
    write_data <= d;
    sda_in     <= s;
    do @(posedge clk); while (in_stall);
    if (((f == FUNC_WRITE || f == FUNC_READ) && m_phase == PH_IDLE) ||
        (f == FUNC_TICK && m_phase != PH_IDLE))
      work_items++;
    bus_expect_q.push_back(advance_bus_model(f, a, d, s));
  endtask

  function automatic logic slave_sda(input int nack_pct);
    if (m_phase == PH_ACK_HI) return ($urandom_range(0, 99) < nack_pct);
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic tick(input int nack_pct);
    send_item(FUNC_TICK, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
              slave_sda(nack_pct));
  endtask

  task automatic send_noise();
    int v;
    v = $urandom_range(0, 2);
    send_item((v == 2) ? FUNC_NONE : 2'(v), 16'($urandom_range(0, 65535)),
              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // drop valid and hold until every result is back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (bus_expect_q.size() != 0);
  endtask

  task automatic write_regs(input logic [DEV_W-1:0] dev, input logic [TIMER_W-1:0] ticks);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_DEVICE_ADDRESS;
    cfg_data  <= 16'(dev);
    do @(posedge clk); while (!cfg_ready);
    model_dev = dev;
    cfg_index <= CFG_PHASE_TICKS;
    cfg_data  <= ticks;
    do @(posedge clk); while (!cfg_ready);
    model_ticks = ticks;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_transfer(input logic [1:0] f, input logic [15:0] a,
                              input logic [7:0] d, input int nack_pct);
    send_item(f, a, d, 1'($urandom_range(0, 1)));
    while (m_phase != PH_IDLE) begin
      if ($urandom_range(0, 99) < 4) send_noise();
      else tick(nack_pct);
    end
  endtask

  task automatic test_idle_items();
    write_regs(7'd127, 16'd1);
    tick(0);
    send_item(FUNC_NONE, 16'hFFFF, 8'hFF, 1'b1);
    tick(0);
  endtask

  task automatic test_early_nack();
    send_item(FUNC_WRITE, 16'hFFFF, 8'hFF, 1'b0);
    send_item(FUNC_READ, 16'h0000, 8'h00, 1'b1);
    send_item(FUNC_NONE, 16'h1234, 8'h5A, 1'b0);
    while (m_phase != PH_IDLE) tick(100);
    write_regs(7'd0, 16'd0);
    send_item(FUNC_READ, 16'h0000, 8'h00, 1'b0);
    while (m_phase != PH_IDLE) tick(100);
  endtask

  task automatic test_slow_phase();
    write_regs(7'($urandom_range(0, 127)), 16'hFFFF);
    tick(0);
    send_item(FUNC_NONE, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)), 1'b0);
    tick(0);
  endtask

  task automatic test_random_transfers();
    logic [DEV_W-1:0] dev;
    logic [15:0]      ticks;
    logic [15:0]      a;
    logic [7:0]       d;
    while (work_items < WORK_TARGET) begin
      steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 5))
        0:       dev = 7'd0;
        1:       dev = 7'd127;
        default: dev = 7'($urandom_range(0, 127));
      endcase
      ticks = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(2, 4)) : 16'd1;
      write_regs(dev, ticks);
      repeat ($urandom_range(1, 3)) begin
        if (work_items >= WORK_TARGET) break;
        if ($urandom_range(0, 3) == 0) send_noise();
        case ($urandom_range(0, 7))
          0:       a = 16'h0000;
          1:       a = 16'hFFFF;
          default: a = 16'($urandom_range(0, 65535));
        endcase
        case ($urandom_range(0, 7))
          0:       d = 8'h00;
          1:       d = 8'hFF;
          default: d = 8'($urandom_range(0, 255));
        endcase
        run_transfer($urandom_range(0, 1) ? FUNC_READ : FUNC_WRITE, a, d,
                     ($urandom_range(0, 3) == 0) ? 8 : 0);
      end
    end
    steady = 1'b0;
  endtask

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    line_status_t e;
    if (!rst && out_valid && !out_stall) begin
      if (bus_expect_q.size() == 0) begin
        $error("result with no request outstanding");
        fails++;
      end else begin
        e = bus_expect_q.pop_front();
        check_field("scl_out", e.scl, scl_out);
        check_field("sda_out", e.sda, sda_out);
        check_field("busy_res", e.busy, busy_res);
        check_field("done_res", e.done, done_res);
        check_field("nack", e.nack, nack);
        check_field("read_data", e.rdata, read_data);
      end
    end
  end

  initial begin : result_stall
    int hold;
    forever begin
      hold = steady ? 0 : $urandom_range(0, 4);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    reset_bus_model();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_idle_items();
    test_early_nack();
    test_slow_phase();
    test_random_transfers();
    settle();
    repeat (8) @(posedge clk);
    if (bus_expect_q.size() != 0) begin
      $error("%0d results never arrived", bus_expect_q.size());
      fails++;
    end
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/i2cebam_pkg.sv
hdl/i2c_eeprom_byte_access_master.sv
tb/tb_i2c_eeprom_byte_access_master.sv
